// File: src/lzop_pkg.sv
// ----------------------------------------------------------------------------
// lzop_pkg
// Shared types and constants of the lzop container header parser.
// ----------------------------------------------------------------------------
package lzop_pkg;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [4:0] KIND_MAGIC   = 5'd0;
	localparam logic [4:0] KIND_VERSION = 5'd1;
	localparam logic [4:0] KIND_LIBVER  = 5'd2;
	localparam logic [4:0] KIND_NEEDVER = 5'd3;
	localparam logic [4:0] KIND_METHOD  = 5'd4;
	localparam logic [4:0] KIND_LEVEL   = 5'd5;
	localparam logic [4:0] KIND_FLAGS   = 5'd6;
	localparam logic [4:0] KIND_FILTER  = 5'd7;
	localparam logic [4:0] KIND_MODE    = 5'd8;
	localparam logic [4:0] KIND_TIMELO  = 5'd9;
	localparam logic [4:0] KIND_TIMEHI  = 5'd10;
	localparam logic [4:0] KIND_NAMELEN = 5'd11;
	localparam logic [4:0] KIND_NAMEBYT = 5'd12;
	localparam logic [4:0] KIND_HDRSUM  = 5'd13;
	localparam logic [4:0] KIND_XLEN    = 5'd14;
	localparam logic [4:0] KIND_XBYTE   = 5'd15;
	localparam logic [4:0] KIND_XSUM    = 5'd16;
	localparam logic [4:0] KIND_USIZE   = 5'd17;
	localparam logic [4:0] KIND_CSIZE   = 5'd18;
	localparam logic [4:0] KIND_USUM    = 5'd19;
	localparam logic [4:0] KIND_CSUM    = 5'd20;
	localparam logic [4:0] KIND_PAYLOAD = 5'd21;
	localparam logic [4:0] KIND_END     = 5'd22;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
	localparam logic [2:0] ST_NRV       = 3'd2;
	localparam logic [2:0] ST_ZLIB      = 3'd3;
	localparam logic [2:0] ST_UNKNOWN   = 3'd4;
	localparam logic [2:0] ST_MULTI     = 3'd5;

	localparam logic [15:0] NEW_VERSION = 16'h0940;
	localparam logic [31:0] FL_ADLER_D  = 32'h0000_0001;
	localparam logic [31:0] FL_ADLER_C  = 32'h0000_0002;
	localparam logic [31:0] FL_EXTRA    = 32'h0000_0040;
	localparam logic [31:0] FL_CRC_D    = 32'h0000_0100;
	localparam logic [31:0] FL_CRC_C    = 32'h0000_0200;
	localparam logic [31:0] FL_MULTI    = 32'h0000_0400;
	localparam logic [31:0] FL_FILTER   = 32'h0000_0800;

	typedef struct packed {
		logic [4:0]  kind;
		logic [63:0] value;
		logic        last;
		logic [2:0]  status;
	} result_t;

	function automatic logic [7:0] magic_byte(input logic [3:0] idx);
		logic [7:0] b;
		unique case (idx)
			4'd0: b = 8'h89;
			4'd1: b = 8'h4c;
			4'd2: b = 8'h5a;
			4'd3: b = 8'h4f;
			4'd4: b = 8'h00;
			4'd5: b = 8'h0d;
			4'd6: b = 8'h0a;
			4'd7: b = 8'h1a;
			4'd8: b = 8'h0a;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [2:0] method_status(input logic [31:0] m);
		logic [2:0] s;
		unique case (m)
			32'd1, 32'd2, 32'd3: s = ST_OK;
			32'h1a, 32'h1b, 32'h2a, 32'h2b, 32'h2d: s = ST_NRV;
			32'd128: s = ST_ZLIB;
			default: s = ST_UNKNOWN;
		endcase
		return s;
	endfunction

endpackage

// File: src/lzop_front.sv
// ----------------------------------------------------------------------------
// lzop_front
// Byte parser: follows the file layout and builds one result per field end,
// string byte or payload byte.
// ----------------------------------------------------------------------------
module lzop_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [7:0]           data_byte,
	input  logic                 stream_start,
	output logic                 res_valid,
	output lzop_pkg::result_t    res
);

	typedef enum logic [4:0] {
		PH_MAGIC, PH_VER, PH_LIB, PH_NEED, PH_METHOD, PH_LEVEL, PH_FLAGS,
		PH_FILTER, PH_MODE, PH_TLO, PH_THI, PH_NLEN, PH_NAME, PH_HSUM,
		PH_XLEN, PH_XBYTE, PH_XSUM, PH_USIZE, PH_CSIZE, PH_UADL, PH_UCRC,
		PH_CADL, PH_CCRC, PH_PAYLOAD
	} phase_t;

	phase_t      phase_q, ph;
	logic [3:0]  byte_index_q, bi;
	logic [31:0] field_shift_q, fs;
	logic [15:0] version_q, ver;
	logic [31:0] flags_q, flg;
	logic [31:0] remaining_q, rem;
	logic [31:0] usize_q, us;
	logic [31:0] csize_q, cs;
	logic [63:0] total_q, tot;
	logic        magic_good_q, mg;
	logic        halted_q, hlt;
	logic        newver;
	logic [31:0] val;

	function automatic logic [3:0] phase_len(input phase_t p);
		logic [3:0] n;
		unique case (p)
			PH_MAGIC: n = 4'd9;
			PH_VER, PH_LIB, PH_NEED: n = 4'd2;
			PH_METHOD, PH_LEVEL, PH_NLEN: n = 4'd1;
			default: n = 4'd4;
		endcase
		return n;
	endfunction

	function automatic logic [4:0] phase_kind(input phase_t p);
		logic [4:0] k;
		unique case (p)
			PH_UADL, PH_UCRC: k = lzop_pkg::KIND_USUM;
			PH_CADL, PH_CCRC: k = lzop_pkg::KIND_CSUM;
			PH_PAYLOAD: k = lzop_pkg::KIND_PAYLOAD;
			default: k = 5'(p);
		endcase
		return k;
	endfunction

	function automatic phase_t block_next(input phase_t from, input logic [31:0] fl,
			input logic [31:0] u, input logic [31:0] c);
		logic   csum;
		phase_t n;
		csum = c < u;
		if (from <= PH_UADL && (fl & lzop_pkg::FL_ADLER_D) != 32'd0) n = PH_UADL;
		else if (from <= PH_UCRC && (fl & lzop_pkg::FL_CRC_D) != 32'd0) n = PH_UCRC;
		else if (from <= PH_CADL && csum && (fl & lzop_pkg::FL_ADLER_C) != 32'd0)
			n = PH_CADL;
		else if (from <= PH_CCRC && csum && (fl & lzop_pkg::FL_CRC_C) != 32'd0)
			n = PH_CCRC;
		else if (c != 32'd0) n = PH_PAYLOAD;
		else n = PH_USIZE;
		return n;
	endfunction

	always_comb begin
		ph = phase_q; bi = byte_index_q; fs = field_shift_q; ver = version_q;
		flg = flags_q; rem = remaining_q; us = usize_q; cs = csize_q;
		tot = total_q; mg = magic_good_q; hlt = halted_q;
		res_valid = 1'b0;
		res = '0;
		val = '0;
		newver = 1'b0;
		if (stream_start) begin
			ph = PH_MAGIC; bi = '0; fs = '0; ver = '0; flg = '0; rem = '0;
			us = '0; cs = '0; tot = '0; mg = 1'b1; hlt = 1'b0;
		end
		if (!hlt) begin
			res.kind = phase_kind(ph);
			newver = ver >= lzop_pkg::NEW_VERSION;
			if (ph == PH_NAME || ph == PH_XBYTE || ph == PH_PAYLOAD) begin
				rem = rem - 32'd1;
				res_valid = 1'b1;
				res.value = {56'd0, data_byte};
				if (rem == 32'd0) begin
					unique case (ph)
						PH_NAME: ph = PH_HSUM;
						PH_XBYTE: ph = PH_XSUM;
						default: begin
							res.last = 1'b1;
							ph = PH_USIZE;
						end
					endcase
				end
			end else begin
				if (ph == PH_MAGIC && data_byte != lzop_pkg::magic_byte(bi))
					mg = 1'b0;
				fs = {fs[23:0], data_byte};
				bi = bi + 4'd1;
				if (bi == phase_len(ph)) begin
					val = fs;
					fs = '0;
					bi = '0;
					res_valid = 1'b1;
					res.value = {32'd0, val};
					unique case (ph)
						PH_MAGIC: begin
							if (!mg) begin
								res.status = lzop_pkg::ST_BAD_MAGIC;
								hlt = 1'b1;
							end else ph = PH_VER;
						end
						PH_VER: begin
							ver = val[15:0];
							ph = PH_LIB;
						end
						PH_LIB: ph = newver ? PH_NEED : PH_METHOD;
						PH_NEED: ph = PH_METHOD;
						PH_METHOD: begin
							res.status = lzop_pkg::method_status(val);
							ph = newver ? PH_LEVEL : PH_FLAGS;
						end
						PH_LEVEL: ph = PH_FLAGS;
						PH_FLAGS: begin
							flg = val;
							if ((val & lzop_pkg::FL_MULTI) != 32'd0)
								res.status = lzop_pkg::ST_MULTI;
							ph = ((val & lzop_pkg::FL_FILTER) != 32'd0) ? PH_FILTER : PH_MODE;
						end
						PH_FILTER: ph = PH_MODE;
						PH_MODE: ph = PH_TLO;
						PH_TLO: ph = newver ? PH_THI : PH_NLEN;
						PH_THI: ph = PH_NLEN;
						PH_NLEN: begin
							rem = val;
							ph = (val != 32'd0) ? PH_NAME : PH_HSUM;
						end
						PH_HSUM: ph = ((flg & lzop_pkg::FL_EXTRA) != 32'd0) ? PH_XLEN : PH_USIZE;
						PH_XLEN: begin
							rem = val;
							ph = (val != 32'd0) ? PH_XBYTE : PH_XSUM;
						end
						PH_XSUM: ph = PH_USIZE;
						PH_USIZE: begin
							if (val == 32'd0) begin
								hlt = 1'b1;
								res.kind = lzop_pkg::KIND_END;
								res.value = tot;
							end else begin
								us = val;
								tot = tot + {32'd0, val};
								ph = PH_CSIZE;
							end
						end
						PH_CSIZE: begin
							cs = val;
							ph = block_next(PH_UADL, flg, us, val);
							if (ph == PH_PAYLOAD) rem = val;
						end
						default: begin
							ph = block_next(phase_t'(ph + 5'd1), flg, us, cs);
							if (ph == PH_PAYLOAD) rem = cs;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC; byte_index_q <= '0; field_shift_q <= '0;
			version_q <= '0; flags_q <= '0; remaining_q <= '0; usize_q <= '0;
			csize_q <= '0; total_q <= '0; magic_good_q <= 1'b1; halted_q <= 1'b0;
		end else if (take) begin
			phase_q <= ph; byte_index_q <= bi; field_shift_q <= fs;
			version_q <= ver; flags_q <= flg; remaining_q <= rem; usize_q <= us;
			csize_q <= cs; total_q <= tot; magic_good_q <= mg; halted_q <= hlt;
		end
	end

endmodule

// File: src/lzop_queue.sv
// ----------------------------------------------------------------------------
// lzop_queue
// Result queue between the parser and the output channel.
// ----------------------------------------------------------------------------
module lzop_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lzop_pkg::result_t    push_data,
	output logic                 has_room,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lzop_pkg::result_t    out_data
);

	lzop_pkg::result_t               mem_q [lzop_pkg::FIFO_DEPTH];
	logic [lzop_pkg::FIFO_AW-1:0]    wr_q, rd_q;
	logic [lzop_pkg::FIFO_AW:0]      count_q;
	logic                            pop;

	assign has_room  = count_q < (lzop_pkg::FIFO_AW+1)'(lzop_pkg::FIFO_DEPTH);
	assign out_valid = count_q != '0;
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			count_q <= count_q + (lzop_pkg::FIFO_AW+1)'(push) - (lzop_pkg::FIFO_AW+1)'(pop);
		end
	end

endmodule

// File: src/lzop_container_header_parser.sv
// ----------------------------------------------------------------------------
// lzop_container_header_parser
// One byte per cycle while the result queue has room; each result is written
// into that queue as its byte is transferred. The 4-entry queue decouples
// the parser from the output, so input stalls only when that queue is full.
// Asynchronous active-low reset returns the parser to the magic phase.
// ----------------------------------------------------------------------------
module lzop_container_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        stream_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  field_kind,
	output logic [63:0] field_value,
	output logic        payload_last,
	output logic [2:0]  status
);

	lzop_pkg::result_t res, head;
	logic              res_valid, take, room;

	assign in_ready = room;
	assign take     = in_valid && room;

	lzop_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.data_byte    (data_byte),
		.stream_start (stream_start),
		.res_valid    (res_valid),
		.res          (res)
	);

	lzop_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && res_valid),
		.push_data (res),
		.has_room  (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (head)
	);

	assign field_kind   = head.kind;
	assign field_value  = head.value;
	assign payload_last = head.last;
	assign status       = head.status;

	a_last_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_last |-> field_kind == lzop_pkg::KIND_PAYLOAD)
		else $error("last flag on non-payload result");

	a_status_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != lzop_pkg::ST_OK |->
		field_kind == lzop_pkg::KIND_MAGIC || field_kind == lzop_pkg::KIND_METHOD ||
		field_kind == lzop_pkg::KIND_FLAGS)
		else $error("status on wrong result kind");

	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_kind == lzop_pkg::KIND_END |->
		status == lzop_pkg::ST_OK && !payload_last)
		else $error("end result carries flags");

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream test of the lzop container header parser. Directed files cover
// old and new header versions, bad magic, every method class, multipart,
// filter and extra fields, empty name, zero-payload blocks and the end block.
// Random files follow, with random flags, names, extra data and block chains,
// plus some noise. A scoreboard predicts each result from the accepted bytes.
// ----------------------------------------------------------------------------
module tb_top;

	class parse_scoreboard;
		logic [4:0]  ph;
		logic [3:0]  bidx;
		logic [31:0] shift_acc;
		logic [15:0] ver;
		logic [31:0] flags;
		logic [31:0] remain;
		logic [31:0] usz;
		logic [31:0] csz;
		logic [63:0] total;
		bit          mgood;
		bit          stopped;
		lzop_pkg::result_t pending[$];
		int          errors;

		function void clear();
			ph = 0; bidx = 0; shift_acc = 0; ver = 0; flags = 0; remain = 0;
			usz = 0; csz = 0; total = 0; mgood = 1; stopped = 0;
		endfunction

		function logic [3:0] field_len(logic [4:0] p);
			case (p)
				0: return 9;
				1, 2, 3: return 2;
				4, 5, 11: return 1;
				12, 15, 23: return 0;
				default: return 4;
			endcase
		endfunction

		function logic [4:0] kind_of(logic [4:0] p);
			if (p <= 19) return p;
			if (p == 20) return lzop_pkg::KIND_USUM;
			if (p <= 22) return lzop_pkg::KIND_CSUM;
			return lzop_pkg::KIND_PAYLOAD;
		endfunction

		function logic [4:0] next_block(logic [4:0] from);
			bit cs;
			cs = csz < usz;
			if (from <= 19 && (flags & lzop_pkg::FL_ADLER_D) != 0) return 19;
			if (from <= 20 && (flags & lzop_pkg::FL_CRC_D) != 0) return 20;
			if (from <= 21 && cs && (flags & lzop_pkg::FL_ADLER_C) != 0) return 21;
			if (from <= 22 && cs && (flags & lzop_pkg::FL_CRC_C) != 0) return 22;
			if (csz != 0) begin
				remain = csz;
				return 23;
			end
			return 17;
		endfunction

		function void add(logic [4:0] k, logic [63:0] v, logic l, logic [2:0] s);
			lzop_pkg::result_t r;
			r.kind = k; r.value = v; r.last = l; r.status = s;
			pending.push_back(r);
		endfunction

		function void note_byte(logic [7:0] b, logic start);
			logic [31:0] v;
			logic [2:0]  st;
			bit          nv;
			logic [4:0]  k;
			if (start) clear();
			if (stopped || ph > 23) return;
			k = kind_of(ph);
			nv = ver >= lzop_pkg::NEW_VERSION;
			st = lzop_pkg::ST_OK;
			if (field_len(ph) == 0) begin
				remain = remain - 1;
				if (remain == 0) begin
					if (ph == 12) ph = 13;
					else if (ph == 15) ph = 16;
					else begin
						ph = 17;
						add(k, {56'd0, b}, 1, lzop_pkg::ST_OK);
						return;
					end
				end
				add(k, {56'd0, b}, 0, lzop_pkg::ST_OK);
				return;
			end
			if (ph == 0 && bidx < 9 && b != lzop_pkg::magic_byte(bidx)) mgood = 0;
			shift_acc = {shift_acc[23:0], b};
			bidx++;
			if (bidx < field_len(ph)) return;
			v = shift_acc;
			shift_acc = 0;
			bidx = 0;
			case (ph)
				0: if (!mgood) begin
					st = lzop_pkg::ST_BAD_MAGIC;
					stopped = 1;
				end else ph = 1;
				1: begin
					ver = v[15:0];
					ph = 2;
				end
				2: ph = nv ? 3 : 4;
				3: ph = 4;
				4: begin
					st = lzop_pkg::method_status(v);
					ph = nv ? 5 : 6;
				end
				5: ph = 6;
				6: begin
					flags = v;
					if ((v & lzop_pkg::FL_MULTI) != 0) st = lzop_pkg::ST_MULTI;
					ph = ((v & lzop_pkg::FL_FILTER) != 0) ? 7 : 8;
				end
				7: ph = 8;
				8: ph = 9;
				9: ph = nv ? 10 : 11;
				10: ph = 11;
				11: begin
					remain = v;
					ph = (v != 0) ? 12 : 13;
				end
				13: ph = ((flags & lzop_pkg::FL_EXTRA) != 0) ? 14 : 17;
				14: begin
					remain = v;
					ph = (v != 0) ? 15 : 16;
				end
				16: ph = 17;
				17: begin
					if (v == 0) begin
						stopped = 1;
						add(lzop_pkg::KIND_END, total, 0, lzop_pkg::ST_OK);
						return;
					end
					usz = v;
					total = total + {32'd0, v};
					ph = 18;
				end
				18: begin
					csz = v;
					ph = next_block(19);
				end
				default: ph = next_block(ph + 5'd1);
			endcase
			add(k, {32'd0, v}, 0, st);
		endfunction

		function void check(lzop_pkg::result_t got);
			lzop_pkg::result_t w;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result kind %0d value %h", $time, got.kind,
					got.value);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.kind != w.kind) begin
				$display("%0t: kind expected %0d actual %0d", $time, w.kind, got.kind);
				errors++;
			end
			if (got.value != w.value) begin
				$display("%0t: value expected %h actual %h", $time, w.value, got.value);
				errors++;
			end
			if (got.last != w.last) begin
				$display("%0t: last expected %0b actual %0b", $time, w.last, got.last);
				errors++;
			end
			if (got.status != w.status) begin
				$display("%0t: status expected %0d actual %0d", $time, w.status,
					got.status);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [7:0]  data_byte = 0;
	logic        stream_start = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [4:0]  field_kind;
	logic [63:0] field_value;
	logic        payload_last;
	logic [2:0]  status;

	parse_scoreboard sb;
	logic [7:0] file_bytes[$];
	int         cycles = 0;
	int         byte_count = 0;
	bit         hold_off = 0;
	bit         stim_done = 0;

	lzop_container_header_parser DUT (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic push_word(logic [31:0] w, int n);
		for (int i = n - 1; i >= 0; i--) file_bytes.push_back(w[8*i +: 8]);
	endtask

	// Build one lzop file into file_bytes.
	task automatic build_file(logic [15:0] ver, logic [31:0] meth, logic [31:0] flg,
		int nlen, int xlen, int nblk, bit bad, bit ends);
		logic [7:0] mg[9] = '{8'h89, 8'h4c, 8'h5a, 8'h4f, 8'h00, 8'h0d, 8'h0a, 8'h1a,
			8'h0a};
		logic [31:0] u, c;
		file_bytes = {};
		foreach (mg[i]) file_bytes.push_back(mg[i]);
		if (bad) file_bytes[$urandom_range(8)] ^= 8'(1 << $urandom_range(7));
		push_word(ver, 2);
		push_word($urandom, 2);
		if (ver >= lzop_pkg::NEW_VERSION) push_word($urandom, 2);
		push_word(meth, 1);
		if (ver >= lzop_pkg::NEW_VERSION) push_word($urandom, 1);
		push_word(flg, 4);
		if (flg & lzop_pkg::FL_FILTER) push_word($urandom, 4);
		push_word($urandom, 4);
		push_word($urandom, 4);
		if (ver >= lzop_pkg::NEW_VERSION) push_word($urandom, 4);
		push_word(nlen, 1);
		repeat (nlen) push_word($urandom, 1);
		push_word($urandom, 4);
		if (flg & lzop_pkg::FL_EXTRA) begin
			push_word(xlen, 4);
			repeat (xlen) push_word($urandom, 1);
			push_word($urandom, 4);
		end
		repeat (nblk) begin
			case ($urandom_range(5))
				0: u = 32'hffff_ffff;
				default: u = $urandom_range(1, 12);
			endcase
			case ($urandom_range(4))
				0: c = 0;
				1: c = u;
				default: c = $urandom_range(1, 8);
			endcase
			if (c > 12) c = $urandom_range(1, 6);
			push_word(u, 4);
			push_word(c, 4);
			if (flg & lzop_pkg::FL_ADLER_D) push_word($urandom, 4);
			if (flg & lzop_pkg::FL_CRC_D) push_word($urandom, 4);
			if (c < u && (flg & lzop_pkg::FL_ADLER_C)) push_word($urandom, 4);
			if (c < u && (flg & lzop_pkg::FL_CRC_C)) push_word($urandom, 4);
			repeat (c) push_word($urandom, 1);
		end
		if (ends) begin
			push_word(0, 4);
			repeat ($urandom_range(2)) push_word($urandom, 1);
		end
	endtask

	task automatic send_byte(logic [7:0] b, logic start);
		in_valid <= 1;
		data_byte <= b;
		stream_start <= start;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b, start);
		byte_count++;
	endtask

	task automatic send_file(bit bursty);
		int burst;
		burst = $urandom_range(1, 20);
		foreach (file_bytes[i]) begin
			send_byte(file_bytes[i], i == 0);
			if (bursty && --burst == 0) begin
				in_valid <= 0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst = $urandom_range(1, 20);
			end
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_method();
		logic [31:0] ms[10] = '{1, 2, 3, 32'h1a, 32'h1b, 32'h2a, 32'h2b, 32'h2d, 128, 0};
		int k;
		k = $urandom_range(10);
		return (k == 10) ? $urandom : ms[k];
	endfunction

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check('{field_kind, field_value, payload_last, status});
	end

	initial begin
		int cnt;
		forever begin
			@(posedge clk);
			if (hold_off) out_ready <= 0;
			else if (cnt < 30) out_ready <= 1;
			else out_ready <= ($urandom_range(3) != 0);
			cnt = (cnt + 1) % 60;
		end
	end

	initial begin
		sb = new();
		sb.clear();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed files
		build_file(16'h0930, 1, 0, 0, 0, 1, 0, 1);
		send_file(0);
		build_file(16'h0940, 32'h2d, 32'hffff_ffff, 3, 2, 2, 0, 1);
		send_file(0);
		drain();
		build_file(16'hffff, 128,
			lzop_pkg::FL_EXTRA | lzop_pkg::FL_ADLER_C | lzop_pkg::FL_CRC_C, 0, 0, 2, 0, 1);
		send_file(0);
		build_file(16'h0000, 32'hdead_beef,
			lzop_pkg::FL_MULTI | lzop_pkg::FL_ADLER_D | lzop_pkg::FL_CRC_D, 1, 0, 2,
			0, 1);
		send_file(1);
		build_file(16'h1040, 3, 0, 0, 0, 1, 1, 1);
		send_file(0);
		// long receiver hold-off while the sender keeps offering bytes
		fork
			begin
				hold_off = 1;
				repeat (60) @(posedge clk);
				hold_off = 0;
			end
			begin
				build_file(16'h0940, 2, lzop_pkg::FL_ADLER_D, 2, 0, 3, 0, 1);
				send_file(0);
			end
		join
		drain();
		while (byte_count < 500) begin
			build_file($urandom_range(1) ? 16'h0940 + $urandom_range(200) :
				16'h0940 - $urandom_range(1, 200), rand_method(),
				$urandom & 32'h0fff | ($urandom_range(7) == 0 ? $urandom : 0),
				$urandom_range(4), $urandom_range(3), $urandom_range(4),
				$urandom_range(12) == 0, $urandom_range(8) != 0);
			if ($urandom_range(10) == 0)
				repeat ($urandom_range(1, 15)) file_bytes.push_back($urandom);
			send_file($urandom_range(2) != 0);
			if ($urandom_range(5) == 0) drain();
		end
		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
src/lzop_pkg.sv
src/lzop_front.sv
src/lzop_queue.sv
src/lzop_container_header_parser.sv
dv/tb_top.sv
